/* sv/indexed_linked_list_engine_core_assert.svh */
// Assertion macros for the linked list engine RTL.
`ifndef INDEXED_LINKED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ILLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ILLE_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ILLE_ASSERT(label, clk, rst_n, prop, msg)
`define ILLE_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* sv/ille_pkg.sv */
// Types and codes of the indexed linked list engine.
package ille_pkg;

	typedef enum logic [2:0] {
		OP_GET  = 3'd0,
		OP_HEAD = 3'd1,
		OP_TAIL = 3'd2,
		OP_AT   = 3'd3,
		OP_DEL  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_ALLOC_WAIT,
		S_WALK,
		S_GET_WAIT,
		S_INS_LINK,
		S_DEL_WAIT,
		S_DEL_FREE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic        [2:0]  operation;
		logic        [10:0] position;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic        [1:0]  status;
	} rsp_t;

endpackage

/* sv/ille_ram.sv */
// Single write port, single read port memory with a registered read.
module ille_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/ille_out_reg.sv */
// Output register for result items, decoupling the engine from a stalled receiver.
module ille_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  ille_pkg::rsp_t load_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ille_pkg::rsp_t rsp
);

	logic valid_q;

	assign load_ready = !valid_q || !rsp_stall;
	assign rsp_valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	// Hold the payload while stalled; take a new item once the slot frees.
	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			rsp <= load_data;
		end
	end

endmodule

/* sv/indexed_linked_list_engine_core.sv */
// Top level of the indexed linked list engine: sequencer around the node stores.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request item:
//   operation, position and item_value. rsp channel (rsp_valid / rsp_stall /
//   rsp) returns exactly one result item per request: read_value and status.
//   Requests are worked one at a time; req_stall is high while an item is in
//   progress. A finished result sits in an output register, so the next item
//   is taken while the receiver still stalls the previous result.
//   A rejected or unknown request goes straight from decode to the response
//   step and on to the output register, and the engine returns to idle before
//   the next item is taken. A walk reads one link per cycle through the single
//   read port of the link memory that every walk step goes through.
//   Reset: the list is empty, the free list is empty and the fill mark is
//   zero. Nodes that were never used are taken from above the fill mark, so
//   no clearing pass of the memories is needed and an item is taken at once.
//   A stalled receiver holds its result; once a second result is ready the
//   engine waits in its response step until the output register frees.
`include "indexed_linked_list_engine_core_assert.svh"

module indexed_linked_list_engine_core #(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ille_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ille_pkg::rsp_t rsp
);

	import ille_pkg::*;

	// Pointer width holds every node index plus the null link (CAPACITY).
	localparam int AW   = $clog2(CAPACITY);
	localparam int PW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (PW > 11) ? PW : 11;
	localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

	state_t state_q, state_d;

	logic [PW-1:0] head_q;   // first list node
	logic [PW-1:0] free_q;   // top of the recycled node stack
	logic [PW-1:0] fill_q;   // nodes at and above this index were never used
	logic [PW-1:0] count_q;  // list entries
	logic [PW-1:0] cur_q;
	logic [PW-1:0] prev_q;
	logic [PW-1:0] node_q;
	logic [PW-1:0] rem_q;    // walk steps still to go
	logic          pend_q;   // a link read is in flight
	logic          zero_q;   // request works at the head
	op_t           op_q;
	logic [VALUE_WIDTH-1:0] val_q;
	rsp_t          res_q;

	logic accept;
	logic out_ready;

	// Link store ports
	logic          link_we, link_re;
	logic [PW-1:0] link_waddr, link_wdata, link_raddr;
	logic [PW-1:0] link_rdata;

	// Value store ports
	logic                   val_we, val_re;
	logic signed [VALUE_WIDTH-1:0] val_rdata;
	logic [PW-1:0]          alloc_node;

	// Request decode
	op_t                req_op;
	logic [CMPW-1:0]    pos_ext, cnt_ext;
	logic               store_full;
	state_t             dec_state;
	rsp_t               dec_res;
	logic [PW-1:0]      dec_rem;
	logic               dec_zero;
	logic signed [63:0] wide_val;

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign req_op     = op_t'(req.operation);
	assign pos_ext    = CMPW'(req.position);
	assign cnt_ext    = CMPW'(count_q);
	assign store_full = (count_q == NULL_PTR);
	assign wide_val   = 64'(req.item_value);
	assign alloc_node = (free_q != NULL_PTR) ? free_q : fill_q;

	// Check the index and the fill level, then choose the first step.
	always_comb begin
		dec_state          = S_RESP;
		dec_res.read_value = '0;
		dec_res.status     = ST_OK;
		dec_rem            = count_q;
		dec_zero           = 1'b0;
		unique case (req_op)
			OP_GET: begin
				if (pos_ext >= cnt_ext) begin
					dec_res.read_value = '1;
					dec_res.status     = ST_BAD_INDEX;
				end else begin
					dec_state = S_WALK;
					dec_rem   = PW'(req.position);
				end
			end
			OP_HEAD: begin
				if (store_full) begin
					dec_res.status = ST_FULL;
				end else begin
					dec_state = S_ALLOC;
					dec_rem   = '0;
					dec_zero  = 1'b1;
				end
			end
			OP_TAIL: begin
				if (store_full) begin
					dec_res.status = ST_FULL;
				end else begin
					dec_state = S_ALLOC;
					dec_rem   = count_q;
					dec_zero  = (count_q == '0);
				end
			end
			OP_AT: begin
				if (pos_ext > cnt_ext) begin
					dec_res.status = ST_BAD_INDEX;
				end else if (store_full) begin
					dec_res.status = ST_FULL;
				end else begin
					dec_state = S_ALLOC;
					dec_rem   = PW'(req.position);
					dec_zero  = (req.position == '0);
				end
			end
			OP_DEL: begin
				if (pos_ext >= cnt_ext) begin
					dec_res.status = ST_BAD_INDEX;
				end else begin
					dec_state = S_WALK;
					dec_rem   = PW'(req.position);
					dec_zero  = (req.position == '0);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d    = state_q;
		link_we    = 1'b0;
		link_waddr = node_q;
		link_wdata = cur_q;
		link_re    = 1'b0;
		link_raddr = cur_q;
		val_we     = 1'b0;
		val_re     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = dec_state;
				end
			end
			S_ALLOC: begin
				// Store the value now; pop the recycled stack if it holds a node.
				val_we = 1'b1;
				if (free_q != NULL_PTR) begin
					link_re    = 1'b1;
					link_raddr = free_q;
					state_d    = S_ALLOC_WAIT;
				end else begin
					state_d = S_WALK;
				end
			end
			S_ALLOC_WAIT: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (pend_q) begin
					// Chain the next read straight from the returned link.
					if (rem_q > PW'(1)) begin
						link_re    = 1'b1;
						link_raddr = link_rdata;
					end
				end else if (rem_q != '0) begin
					link_re = 1'b1;
				end else begin
					case (op_q)
						OP_GET: begin
							val_re  = 1'b1;
							state_d = S_GET_WAIT;
						end
						OP_DEL: begin
							link_re = 1'b1;
							state_d = S_DEL_WAIT;
						end
						default: begin
							// New node points at the node now at its index.
							link_we = 1'b1;
							state_d = zero_q ? S_RESP : S_INS_LINK;
						end
					endcase
				end
			end
			S_GET_WAIT: begin
				state_d = S_RESP;
			end
			S_INS_LINK: begin
				link_we    = 1'b1;
				link_waddr = prev_q;
				link_wdata = node_q;
				state_d    = S_RESP;
			end
			S_DEL_WAIT: begin
				// Unhook the victim from its predecessor.
				if (!zero_q) begin
					link_we    = 1'b1;
					link_waddr = prev_q;
					link_wdata = link_rdata;
				end
				state_d = S_DEL_FREE;
			end
			S_DEL_FREE: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = free_q;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// List bookkeeping: head, recycled stack, fill mark, entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_PTR;
			free_q  <= NULL_PTR;
			fill_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_ALLOC: begin
					if (free_q == NULL_PTR) begin
						fill_q <= fill_q + PW'(1);
					end
				end
				S_ALLOC_WAIT: begin
					free_q <= link_rdata;
				end
				S_WALK: begin
					if (pend_q) begin
						pend_q <= (rem_q > PW'(1));
					end else if (rem_q != '0) begin
						pend_q <= 1'b1;
					end else if (op_q != OP_GET && op_q != OP_DEL && zero_q) begin
						head_q  <= node_q;
						count_q <= count_q + PW'(1);
					end
				end
				S_INS_LINK: begin
					count_q <= count_q + PW'(1);
				end
				S_DEL_WAIT: begin
					if (zero_q) begin
						head_q <= link_rdata;
					end
				end
				S_DEL_FREE: begin
					free_q  <= cur_q;
					count_q <= count_q - PW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Request payload and walk position.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= req_op;
					rem_q  <= dec_rem;
					zero_q <= dec_zero;
					cur_q  <= head_q;
					res_q  <= dec_res;
					val_q  <= wide_val[VALUE_WIDTH-1:0];
				end
			end
			S_ALLOC: begin
				node_q <= alloc_node;
			end
			S_WALK: begin
				if (pend_q) begin
					prev_q <= cur_q;
					cur_q  <= link_rdata;
					rem_q  <= rem_q - PW'(1);
				end
			end
			S_GET_WAIT: begin
				res_q.read_value <= 32'(val_rdata);
			end
			default: begin
			end
		endcase
	end

	ille_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (PW)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr[AW-1:0]),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr[AW-1:0]),
		.rdata (link_rdata)
	);

	ille_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (alloc_node[AW-1:0]),
		.wdata (val_q),
		.re    (val_re),
		.raddr (cur_q[AW-1:0]),
		.rdata (val_rdata)
	);

	ille_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (state_q == S_RESP),
		.load_ready (out_ready),
		.load_data  (res_q),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	// Entries in use never exceed the nodes handed out, nor those the capacity.
	`ILLE_ASSERT(a_fill_bound, clk, arst_n, count_q <= fill_q && fill_q <= NULL_PTR, "node count out of bounds")
	// The link store is never read and written in the same cycle.
	`ILLE_NEVER(a_link_port, clk, arst_n, link_we && link_re, "link read collides with write")
	// An accepted item keeps the engine busy in the next cycle.
	`ILLE_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> req_stall, "engine idle after accept")
	// A result handed to a free output register shows up as valid.
	`ILLE_ASSERT(a_result_delivered, clk, arst_n, (state_q == S_RESP) && out_ready |=> rsp_valid, "result lost")

endmodule
